// File: hw/rtl/kts_pkg.sv
package kts_pkg;

  // Table size and number formats.
  localparam int MAX_KEYS   = 64;
  localparam int ADDR_W     = $clog2(MAX_KEYS);
  localparam int CNT_W      = $clog2(MAX_KEYS + 1);
  localparam int DATA_W     = 32;
  localparam int FRAC_BITS  = 16;
  localparam int IDX_IN_W   = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int STEP_W     = $clog2(DATA_W);
  localparam int PROD_W     = DATA_W + FRAC_BITS + 3;

  // Request kinds.
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_COUNT     = 2'd0,
    CFG_LOOPING       = 2'd1,
    CFG_LOOP_DURATION = 2'd2,
    CFG_EMPTY_FILL    = 2'd3
  } cfg_reg_t;

  // Key memory read address source.
  typedef enum logic [1:0] {
    RS_FIRST,
    RS_LAST,
    RS_IDX,
    RS_IDX_M1
  } rd_src_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_T0,
    ST_TL,
    ST_MOD,
    ST_MOD_FIN,
    ST_SRCH_INIT,
    ST_SRCH_RD,
    ST_SRCH_CHK,
    ST_DIV,
    ST_VAL_A,
    ST_VAL_B,
    ST_MUL,
    ST_ADD,
    ST_EMIT,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    wr_key;
    logic    load_sample;
    rd_src_t rd_src;
    logic    cap_t0;
    logic    mod_init;
    logic    mod_step;
    logic    mod_done;
    logic    srch_init;
    logic    srch_adv;
    logic    div_init;
    logic    div_step;
    logic    cap_a;
    logic    cap_b;
    logic    mul;
    logic    add;
    logic    emit_key;
    logic    emit_fill;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic n_zero;
    logic lt_first;
    logic le_first;
    logic ge_last;
    logic wrap_ok;
    logic need_mod;
    logic seg_hit;
    logic idx_end;
  } status_t;

endpackage

// File: hw/rtl/kts_in_if.sv
interface kts_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  req_type;
  logic [kts_pkg::IDX_IN_W-1:0]          key_index;
  logic signed [kts_pkg::DATA_W-1:0]     time_value;
  logic signed [kts_pkg::DATA_W-1:0]     value_x;
  logic signed [kts_pkg::DATA_W-1:0]     value_y;
  logic signed [kts_pkg::DATA_W-1:0]     value_z;

  modport source (output valid, req_type, key_index, time_value, value_x, value_y, value_z,
                  input ready);
  modport sink (input valid, req_type, key_index, time_value, value_x, value_y, value_z,
                output ready);
endinterface

interface kts_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [kts_pkg::DATA_W-1:0]     out_x;
  logic signed [kts_pkg::DATA_W-1:0]     out_y;
  logic signed [kts_pkg::DATA_W-1:0]     out_z;

  modport source (output valid, out_x, out_y, out_z, input ready);
  modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

// File: hw/rtl/kts_ctrl.sv
module kts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_req_type,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  kts_pkg::status_t  sts,
  output kts_pkg::cmd_t     cmd
);

  kts_pkg::state_t                 state_r, state_nxt;
  logic [kts_pkg::STEP_W-1:0]      cnt_r, cnt_nxt;
  logic [1:0]                      comp_r, comp_nxt;

  // State and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kts_pkg::ST_IDLE;
      cnt_r   <= '0;
      comp_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      comp_r  <= comp_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    comp_nxt  = comp_r;
    cmd       = '0;
    cmd.rd_src = kts_pkg::RS_FIRST;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      kts_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_req_type == kts_pkg::REQ_WRITE) begin
            cmd.wr_key = 1'b1;
          end else if (sts.n_zero) begin
            cmd.emit_fill = 1'b1;
            state_nxt = kts_pkg::ST_OUT;
          end else begin
            cmd.load_sample = 1'b1;
            cmd.rd_src = kts_pkg::RS_FIRST;
            state_nxt = kts_pkg::ST_T0;
          end
        end
      end
      kts_pkg::ST_T0: begin
        cmd.cap_t0 = 1'b1;
        cmd.rd_src = kts_pkg::RS_LAST;
        state_nxt = kts_pkg::ST_TL;
      end
      kts_pkg::ST_TL: begin
        if (sts.lt_first) begin
          cmd.rd_src = kts_pkg::RS_FIRST;
          state_nxt = kts_pkg::ST_EMIT;
        end else if (sts.ge_last && !sts.wrap_ok) begin
          cmd.rd_src = kts_pkg::RS_LAST;
          state_nxt = kts_pkg::ST_EMIT;
        end else if (sts.ge_last && sts.need_mod) begin
          cmd.mod_init = 1'b1;
          cnt_nxt = '0;
          state_nxt = kts_pkg::ST_MOD;
        end else begin
          state_nxt = kts_pkg::ST_SRCH_INIT;
        end
      end
      kts_pkg::ST_MOD: begin
        cmd.mod_step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == kts_pkg::STEP_W'(kts_pkg::DATA_W - 1)) begin
          state_nxt = kts_pkg::ST_MOD_FIN;
        end
      end
      kts_pkg::ST_MOD_FIN: begin
        cmd.mod_done = 1'b1;
        state_nxt = kts_pkg::ST_SRCH_INIT;
      end
      kts_pkg::ST_SRCH_INIT: begin
        cmd.srch_init = 1'b1;
        state_nxt = kts_pkg::ST_SRCH_RD;
      end
      kts_pkg::ST_SRCH_RD: begin
        // Past the last segment: clamp to an end key.
        if (sts.idx_end) begin
          cmd.rd_src = sts.le_first ? kts_pkg::RS_FIRST : kts_pkg::RS_LAST;
          state_nxt = kts_pkg::ST_EMIT;
        end else begin
          cmd.rd_src = kts_pkg::RS_IDX;
          state_nxt = kts_pkg::ST_SRCH_CHK;
        end
      end
      kts_pkg::ST_SRCH_CHK: begin
        if (sts.seg_hit) begin
          cmd.div_init = 1'b1;
          cnt_nxt = '0;
          state_nxt = kts_pkg::ST_DIV;
        end else begin
          cmd.srch_adv = 1'b1;
          state_nxt = kts_pkg::ST_SRCH_RD;
        end
      end
      kts_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cmd.rd_src = kts_pkg::RS_IDX_M1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == kts_pkg::STEP_W'(kts_pkg::FRAC_BITS - 1)) begin
          state_nxt = kts_pkg::ST_VAL_A;
        end
      end
      kts_pkg::ST_VAL_A: begin
        cmd.cap_a = 1'b1;
        cmd.rd_src = kts_pkg::RS_IDX;
        state_nxt = kts_pkg::ST_VAL_B;
      end
      kts_pkg::ST_VAL_B: begin
        cmd.cap_b = 1'b1;
        comp_nxt = '0;
        state_nxt = kts_pkg::ST_MUL;
      end
      kts_pkg::ST_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = kts_pkg::ST_ADD;
      end
      kts_pkg::ST_ADD: begin
        cmd.add = 1'b1;
        comp_nxt = comp_r + 1'b1;
        state_nxt = (comp_r == 2'd2) ? kts_pkg::ST_OUT : kts_pkg::ST_MUL;
      end
      kts_pkg::ST_EMIT: begin
        cmd.emit_key = 1'b1;
        state_nxt = kts_pkg::ST_OUT;
      end
      kts_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = kts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = kts_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/kts_dp.sv
module kts_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [kts_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [kts_pkg::DATA_W-1:0]         cfg_wdata,
  input  logic [kts_pkg::IDX_IN_W-1:0]       in_key_index,
  input  logic signed [kts_pkg::DATA_W-1:0]  in_time_value,
  input  logic signed [kts_pkg::DATA_W-1:0]  in_value_x,
  input  logic signed [kts_pkg::DATA_W-1:0]  in_value_y,
  input  logic signed [kts_pkg::DATA_W-1:0]  in_value_z,
  input  kts_pkg::cmd_t                      cmd,
  output kts_pkg::status_t                   sts,
  output logic signed [kts_pkg::DATA_W-1:0]  out_x,
  output logic signed [kts_pkg::DATA_W-1:0]  out_y,
  output logic signed [kts_pkg::DATA_W-1:0]  out_z
);

  localparam int DW = kts_pkg::DATA_W;
  localparam int FB = kts_pkg::FRAC_BITS;

  // Configuration registers.
  logic [kts_pkg::CNT_W-1:0]  key_count_r;
  logic                       looping_r;
  logic signed [DW-1:0]       loop_dur_r;
  logic signed [DW-1:0]       fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r <= '0;
      looping_r   <= 1'b0;
      loop_dur_r  <= '0;
      fill_r      <= '0;
    end else if (cfg_we) begin
      case (kts_pkg::cfg_reg_t'(cfg_index))
        kts_pkg::CFG_KEY_COUNT:     key_count_r <= cfg_wdata[kts_pkg::CNT_W-1:0];
        kts_pkg::CFG_LOOPING:       looping_r   <= cfg_wdata[0];
        kts_pkg::CFG_LOOP_DURATION: loop_dur_r  <= cfg_wdata;
        kts_pkg::CFG_EMPTY_FILL:    fill_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Keys in use, saturated at the table size.
  logic [kts_pkg::CNT_W-1:0] n_keys, n_m1;
  assign n_keys = (key_count_r > kts_pkg::CNT_W'(kts_pkg::MAX_KEYS))
                ? kts_pkg::CNT_W'(kts_pkg::MAX_KEYS) : key_count_r;
  assign n_m1 = n_keys - 1'b1;

  // Search index and its read address.
  logic [kts_pkg::CNT_W-1:0]  idx_r;
  logic [kts_pkg::CNT_W-1:0]  idx_m1;
  logic [kts_pkg::ADDR_W-1:0] rd_addr;
  assign idx_m1 = idx_r - 1'b1;

  always_comb begin
    case (cmd.rd_src)
      kts_pkg::RS_FIRST:  rd_addr = '0;
      kts_pkg::RS_LAST:   rd_addr = n_m1[kts_pkg::ADDR_W-1:0];
      kts_pkg::RS_IDX:    rd_addr = idx_r[kts_pkg::ADDR_W-1:0];
      kts_pkg::RS_IDX_M1: rd_addr = idx_m1[kts_pkg::ADDR_W-1:0];
      default:            rd_addr = '0;
    endcase
  end

  // Key memories: one write port, one registered read port.
  logic [DW-1:0]    time_mem [kts_pkg::MAX_KEYS];
  logic [2*DW-1:0]  xy_mem   [kts_pkg::MAX_KEYS];
  logic [DW-1:0]    z_mem    [kts_pkg::MAX_KEYS];
  logic signed [DW-1:0] time_rd_r;
  logic [2*DW-1:0]      xy_rd_r;
  logic signed [DW-1:0] z_rd_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_key) begin
      time_mem[in_key_index[kts_pkg::ADDR_W-1:0]] <= in_time_value;
      xy_mem[in_key_index[kts_pkg::ADDR_W-1:0]]   <= {in_value_y, in_value_x};
      z_mem[in_key_index[kts_pkg::ADDR_W-1:0]]    <= in_value_z;
    end
    time_rd_r <= time_mem[rd_addr];
    xy_rd_r   <= xy_mem[rd_addr];
    z_rd_r    <= z_mem[rd_addr];
  end

  // Sample time, first key time and previous segment start.
  logic signed [DW-1:0] t_r, t0_r, prev_r;
  logic [DW-1:0] mod_rem_r, mod_dvd_r;
  logic [DW:0]   mod_r2, mod_den;
  assign mod_r2  = {mod_rem_r, mod_dvd_r[DW-1]};
  assign mod_den = {1'b0, loop_dur_r};

  always_ff @(posedge clk) begin
    if (cmd.load_sample) t_r <= in_time_value;
    else if (cmd.mod_done) t_r <= mod_rem_r + 1'b1;
    if (cmd.cap_t0) t0_r <= time_rd_r;
    if (cmd.srch_init) prev_r <= t0_r;
    else if (cmd.srch_adv) prev_r <= time_rd_r;
    // Remainder of the loop wrap, one bit per step.
    if (cmd.mod_init) begin
      mod_rem_r <= '0;
      mod_dvd_r <= t_r - 1'b1;
    end else if (cmd.mod_step) begin
      mod_rem_r <= (mod_r2 >= mod_den) ? DW'(mod_r2 - mod_den) : mod_r2[DW-1:0];
      mod_dvd_r <= {mod_dvd_r[DW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.srch_init) begin
      idx_r <= kts_pkg::CNT_W'(1);
    end else if (cmd.srch_adv) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  // Fraction divider: quotient of (t - t0) << FRAC_BITS by (t1 - t0).
  logic [DW:0]   diff_w, den_w, den_r;
  logic          q0;
  logic [DW+1:0] drem_r, div_r2;
  logic [FB:0]   frac_r;
  assign diff_w = DW'(0) + ({t_r[DW-1], t_r} - {prev_r[DW-1], prev_r});
  assign den_w  = {time_rd_r[DW-1], time_rd_r} - {prev_r[DW-1], prev_r};
  assign q0     = (diff_w >= den_w);
  assign div_r2 = {drem_r[DW:0], 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      den_r  <= den_w;
      drem_r <= {1'b0, q0 ? (diff_w - den_w) : diff_w};
      frac_r <= {{FB{1'b0}}, q0};
    end else if (cmd.div_step) begin
      if (div_r2 >= {1'b0, den_r}) begin
        drem_r <= div_r2 - {1'b0, den_r};
        frac_r <= {frac_r[FB-1:0], 1'b1};
      end else begin
        drem_r <= div_r2;
        frac_r <= {frac_r[FB-1:0], 1'b0};
      end
    end
  end

  // Interpolation: component queues rotate so slot 0 is always the active one.
  logic signed [DW-1:0]     a_r [3];
  logic signed [DW-1:0]     b_r [3];
  logic signed [DW-1:0]     res_r [3];
  logic signed [DW:0]       delta;
  logic signed [kts_pkg::PROD_W-1:0] prod_r, prod_sh;
  assign delta   = {b_r[0][DW-1], b_r[0]} - {a_r[0][DW-1], a_r[0]};
  assign prod_sh = prod_r >>> FB;

  always_ff @(posedge clk) begin
    if (cmd.cap_a) begin
      a_r[0] <= xy_rd_r[DW-1:0];
      a_r[1] <= xy_rd_r[2*DW-1:DW];
      a_r[2] <= z_rd_r;
    end else if (cmd.add) begin
      a_r[0] <= a_r[1];
      a_r[1] <= a_r[2];
    end
    if (cmd.cap_b) begin
      b_r[0] <= xy_rd_r[DW-1:0];
      b_r[1] <= xy_rd_r[2*DW-1:DW];
      b_r[2] <= z_rd_r;
    end else if (cmd.add) begin
      b_r[0] <= b_r[1];
      b_r[1] <= b_r[2];
    end
    if (cmd.mul) begin
      prod_r <= kts_pkg::PROD_W'(delta) * kts_pkg::PROD_W'($signed({1'b0, frac_r}));
    end
    if (cmd.add) begin
      res_r[2] <= a_r[0] + prod_sh[DW-1:0];
      res_r[1] <= res_r[2];
      res_r[0] <= res_r[1];
    end else if (cmd.emit_key) begin
      res_r[0] <= xy_rd_r[DW-1:0];
      res_r[1] <= xy_rd_r[2*DW-1:DW];
      res_r[2] <= z_rd_r;
    end else if (cmd.emit_fill) begin
      res_r[0] <= fill_r;
      res_r[1] <= fill_r;
      res_r[2] <= fill_r;
    end
  end

  assign out_x = res_r[0];
  assign out_y = res_r[1];
  assign out_z = res_r[2];

  // Status back to the controller.
  assign sts.n_zero   = (n_keys == '0);
  assign sts.lt_first = (t_r < t0_r);
  assign sts.le_first = (t_r <= t0_r);
  assign sts.ge_last  = (t_r >= time_rd_r);
  assign sts.wrap_ok  = looping_r && (loop_dur_r > 0);
  assign sts.need_mod = (t_r > loop_dur_r);
  assign sts.seg_hit  = (t_r > prev_r) && (t_r <= time_rd_r);
  assign sts.idx_end  = (idx_r == n_keys);

endmodule

// File: hw/rtl/keyframe_track_lerp_sampler.sv
// Keyframe track sampler with linear interpolation, signed Q16.16.
// Input channel in_chan carries requests: a write request stores one key
// (time and x, y, z) in the slot given by key_index and returns nothing; a
// sample request returns one interpolated x, y, z on out_chan.
// The configuration port (cfg_we, cfg_index, cfg_wdata) sets the key count,
// looping, loop duration and empty fill; write it only while idle.
// A write request stores its key and returns nothing. A sample with an empty
// table answers with the fill value. Otherwise a sample fetches the end keys,
// wraps the time around the loop when it lies past the end (bit-serial remainder),
// starts the sequential table search and reads one key per visit (one memory read
// port), runs the bit-serial fraction divide, fetches the keys and runs the three
// components through one shared multiplier, and presents the result.
// One request is in flight at a time; the result is held on out_chan until
// taken, and a stalled receiver holds off new requests.
// Reset clears the controller and configuration; key slots are undefined
// until written.
module keyframe_track_lerp_sampler (
  input  logic                          clk,
  input  logic                          rst_n,
  kts_in_if.sink                        in_chan,
  kts_out_if.source                     out_chan,
  input  logic                          cfg_we,
  input  logic [kts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kts_pkg::DATA_W-1:0]    cfg_wdata
);

  kts_pkg::cmd_t    cmd;
  kts_pkg::status_t sts;

  // Controller.
  kts_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_chan.valid),
    .in_req_type (in_chan.req_type),
    .in_ready    (in_chan.ready),
    .out_valid   (out_chan.valid),
    .out_ready   (out_chan.ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  // Datapath.
  kts_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_key_index  (in_chan.key_index),
    .in_time_value (in_chan.time_value),
    .in_value_x    (in_chan.value_x),
    .in_value_y    (in_chan.value_y),
    .in_value_z    (in_chan.value_z),
    .cmd           (cmd),
    .sts           (sts),
    .out_x         (out_chan.out_x),
    .out_y         (out_chan.out_y),
    .out_z         (out_chan.out_z)
  );

`ifndef ASSERT_OFF
  // A pending result blocks new requests.
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_chan.valid && in_chan.ready))
    else $error("request accepted while a result is pending");

  // A sample on an empty table answers in the next cycle.
  a_empty_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && in_chan.req_type == kts_pkg::REQ_SAMPLE
     && sts.n_zero) |=> out_chan.valid)
    else $error("empty table sample did not answer");

  // A key write produces no result and leaves the block ready.
  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && in_chan.req_type == kts_pkg::REQ_WRITE)
    |=> (in_chan.ready && !out_chan.valid))
    else $error("key write disturbed the request flow");
`endif

endmodule

// File: sim/kts_track_checker.sv
`timescale 1ns / 1ps

module kts_track_checker (
  input  logic clk,
  input  logic rst_n,
  kts_in_if    in_mon,
  kts_out_if   out_mon,
  input  logic cfg_we,
  input  logic [kts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kts_pkg::DATA_W-1:0] cfg_wdata,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic [kts_pkg::DATA_W-1:0] x;
    logic [kts_pkg::DATA_W-1:0] y;
    logic [kts_pkg::DATA_W-1:0] z;
  } vec3_t;

  // Shadow copy of the key table and the registers.
  logic [kts_pkg::DATA_W-1:0] key_t [kts_pkg::MAX_KEYS];
  vec3_t                      key_v [kts_pkg::MAX_KEYS];
  logic [6:0]                 n_keys;
  logic                       loop_on;
  logic [kts_pkg::DATA_W-1:0] loop_len;
  logic [kts_pkg::DATA_W-1:0] fill_val;

  vec3_t want_vals[$];

  // One component of a + (b - a) * f, with the product floored.
  function automatic logic [kts_pkg::DATA_W-1:0] lerp_q(longint a, longint b, longint f);
    longint p;
    p = (b - a) * f;
    return kts_pkg::DATA_W'(a + (p >>> kts_pkg::FRAC_BITS));
  endfunction

  // Track value at sample time ts.
  function automatic vec3_t sample_track(logic [kts_pkg::DATA_W-1:0] ts);
    int     n;
    int     last;
    longint t;
    longint d;
    longint t0;
    longint t1;
    longint frac;
    vec3_t  r;
    n = (n_keys > kts_pkg::MAX_KEYS) ? kts_pkg::MAX_KEYS : int'(n_keys);
    if (n == 0) begin
      r = '{fill_val, fill_val, fill_val};
      return r;
    end
    last = n - 1;
    t = longint'($signed(ts));
    if (t < longint'($signed(key_t[0]))) return key_v[0];
    if (t >= longint'($signed(key_t[last]))) begin
      d = longint'($signed(loop_len));
      if (!loop_on || d <= 0) return key_v[last];
      if (t > d) t = ((t - 1) % d) + 1;
    end
    // Sequential search for the first segment t0 < t <= t1.
    for (int i = 1; i < n; i++) begin
      t0 = longint'($signed(key_t[i-1]));
      t1 = longint'($signed(key_t[i]));
      if (t > t0 && t <= t1) begin
        frac = ((t - t0) << kts_pkg::FRAC_BITS) / (t1 - t0);
        r.x = lerp_q(longint'($signed(key_v[i-1].x)), longint'($signed(key_v[i].x)), frac);
        r.y = lerp_q(longint'($signed(key_v[i-1].y)), longint'($signed(key_v[i].y)), frac);
        r.z = lerp_q(longint'($signed(key_v[i-1].z)), longint'($signed(key_v[i].z)), frac);
        return r;
      end
    end
    if (t <= longint'($signed(key_t[0]))) return key_v[0];
    return key_v[last];
  endfunction

  assign pending = want_vals.size();

  // Watch the channels, predict on each request and compare each result.
  always @(posedge clk) begin
    vec3_t got;
    vec3_t exp_v;
    if (!rst_n) begin
      n_keys     <= '0;
      loop_on    <= 1'b0;
      loop_len   <= '0;
      fill_val   <= '0;
      fail_count <= 0;
      want_vals.delete();
    end else begin
      if (cfg_we) begin
        case (kts_pkg::cfg_reg_t'(cfg_index))
          kts_pkg::CFG_KEY_COUNT:     n_keys   <= cfg_wdata[6:0];
          kts_pkg::CFG_LOOPING:       loop_on  <= cfg_wdata[0];
          kts_pkg::CFG_LOOP_DURATION: loop_len <= cfg_wdata;
          kts_pkg::CFG_EMPTY_FILL:    fill_val <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.req_type == kts_pkg::REQ_WRITE) begin
          key_t[in_mon.key_index] <= in_mon.time_value;
          key_v[in_mon.key_index] <= '{in_mon.value_x, in_mon.value_y, in_mon.value_z};
        end else begin
          want_vals.push_back(sample_track(in_mon.time_value));
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.out_x, out_mon.out_y, out_mon.out_z};
        if (want_vals.size() == 0) begin
          if (fail_count < 10) $display("Unexpected result x=%h y=%h z=%h", got.x, got.y, got.z);
          fail_count <= fail_count + 1;
        end else begin
          exp_v = want_vals.pop_front();
          if (got !== exp_v) begin
            if (fail_count < 10)
              $display("Mismatch: expected x=%h y=%h z=%h, got x=%h y=%h z=%h",
                       exp_v.x, exp_v.y, exp_v.z, got.x, got.y, got.z);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// File: sim/keyframe_track_lerp_sampler_tb.sv
`timescale 1ns / 1ps

module keyframe_track_lerp_sampler_tb;

  localparam int IDLE_LIMIT = 6000;
  localparam int HOLD_LEN   = 400;
  localparam int SETTLE     = 250;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [kts_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [kts_pkg::DATA_W-1:0] cfg_wdata;
  int   fail_count;
  int   pending;

  // Idle modes: 0 none, 1 sender, 2 receiver, 3 both lightly.
  int   idle_mode;
  bit   want_hold;
  int   idle_cycles;

  // Key times as loaded, used to aim sample times.
  logic [kts_pkg::DATA_W-1:0] slot_time [kts_pkg::MAX_KEYS];
  logic [kts_pkg::DATA_W-1:0] cur_len;

  kts_in_if  in_chan ();
  kts_out_if out_chan ();

  keyframe_track_lerp_sampler u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  kts_track_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_chan),
    .out_mon   (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver side: random stalls, plus one long hold-off on demand.
  always @(negedge clk) begin
    if (want_hold) begin
      want_hold = 1'b0;
      out_chan.ready <= 1'b0;
      repeat (HOLD_LEN) @(negedge clk);
    end
    case (idle_mode)
      2:       out_chan.ready <= ($urandom_range(99) >= 76);
      3:       out_chan.ready <= ($urandom_range(99) >= 9);
      default: out_chan.ready <= 1'b1;
    endcase
  end

  // Watchdog on cycles with no accepted request or result.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one request and hold it until it is taken.
  task automatic send_req(logic kind, logic [5:0] slot, logic [kts_pkg::DATA_W-1:0] t,
                          logic [kts_pkg::DATA_W-1:0] vx, logic [kts_pkg::DATA_W-1:0] vy,
                          logic [kts_pkg::DATA_W-1:0] vz);
    int gap_pct;
    gap_pct = (idle_mode == 1) ? 76 : (idle_mode == 3) ? 9 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.req_type   <= kind;
    in_chan.key_index  <= slot;
    in_chan.time_value <= t;
    in_chan.value_x    <= vx;
    in_chan.value_y    <= vy;
    in_chan.value_z    <= vz;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  task automatic write_key(logic [5:0] slot, logic [kts_pkg::DATA_W-1:0] t);
    slot_time[slot] = t;
    send_req(kts_pkg::REQ_WRITE, slot, t, $urandom, $urandom, $urandom);
  endtask

  task automatic sample_at(logic [kts_pkg::DATA_W-1:0] t);
    send_req(kts_pkg::REQ_SAMPLE, 6'($urandom), t, $urandom, $urandom, $urandom);
  endtask

  // Drain every result and let the block settle before a register write.
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // One register write, with the enable dropped afterwards.
  task automatic set_reg(kts_pkg::cfg_reg_t idx, logic [kts_pkg::DATA_W-1:0] val);
    if (idx == kts_pkg::CFG_LOOP_DURATION) cur_len = val;
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // Sample times aimed at keys, segment interiors, ends and wrap range.
  function automatic logic [kts_pkg::DATA_W-1:0] pick_time();
    int k;
    k = $urandom_range(kts_pkg::MAX_KEYS - 1);
    case ($urandom_range(9))
      0:       return slot_time[k];
      1:       return slot_time[k] + 1;
      2:       return slot_time[k] - 1;
      3:       return $urandom;
      4:       return 32'h8000_0000;
      5:       return 32'h7fff_ffff;
      6:       return slot_time[kts_pkg::MAX_KEYS-1] + $urandom_range(32'h3fff_ffff);
      7:       return cur_len * $urandom_range(1, 3) + $urandom_range(3) - 1;
      default: return slot_time[k] + $urandom_range(32'h0100_0000);
    endcase
  endfunction

  // Key writes mostly keep the table ascending; a few are arbitrary.
  task automatic random_write();
    int k;
    logic [kts_pkg::DATA_W-1:0] t;
    k = $urandom_range(kts_pkg::MAX_KEYS - 1);
    if ($urandom_range(9) == 0)
      t = $urandom;
    else
      t = 32'hc000_0000 + k * 32'h0100_0000 + $urandom_range(32'h00ff_ffff);
    write_key(6'(k), t);
  endtask

  initial begin
    int count_opts[6];
    logic [kts_pkg::DATA_W-1:0] d;
    count_opts = '{0, 1, 2, 64, 127, 33};
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    idle_mode      = 0;
    cur_len        = '0;
    in_chan.valid  = 1'b0;
    in_chan.req_type   = kts_pkg::REQ_WRITE;
    in_chan.key_index  = '0;
    in_chan.time_value = '0;
    in_chan.value_x    = '0;
    in_chan.value_y    = '0;
    in_chan.value_z    = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Empty table answers with the fill value.
    sample_at(32'h1234_5678);
    drain();
    set_reg(kts_pkg::CFG_EMPTY_FILL, 32'h8000_0000);
    sample_at(32'h8000_0000);
    drain();
    set_reg(kts_pkg::CFG_EMPTY_FILL, 32'h7fff_ffff);
    sample_at(32'h7fff_ffff);

    // Load the whole table, ascending, with extreme values in the first two slots.
    for (int i = 0; i < kts_pkg::MAX_KEYS; i++) begin
      slot_time[i] = 32'hc000_0000 + i * 32'h0100_0000;
      if (i == 0)
        send_req(kts_pkg::REQ_WRITE, 6'(i), slot_time[i], 32'h8000_0000, 32'h7fff_ffff, '0);
      else if (i == 1)
        send_req(kts_pkg::REQ_WRITE, 6'(i), slot_time[i], 32'h7fff_ffff, 32'h8000_0000,
                 32'hffff_ffff);
      else
        send_req(kts_pkg::REQ_WRITE, 6'(i), slot_time[i], $urandom, $urandom, $urandom);
    end
    drain();

    // Count above the table size saturates; hit ends, keys and interiors.
    set_reg(kts_pkg::CFG_KEY_COUNT, 32'd127);
    sample_at(32'h8000_0000);
    sample_at(slot_time[0]);
    sample_at(slot_time[0] + 1);
    sample_at(slot_time[1]);
    sample_at(slot_time[0] + 32'h0080_0000);
    sample_at(slot_time[kts_pkg::MAX_KEYS-1]);
    sample_at(32'h7fff_ffff);
    drain();

    // Looping with zero and negative durations holds the last key.
    set_reg(kts_pkg::CFG_LOOPING, 32'd1);
    sample_at(32'h7fff_ffff);
    drain();
    set_reg(kts_pkg::CFG_LOOP_DURATION, 32'hffff_fffb);
    sample_at(slot_time[kts_pkg::MAX_KEYS-1] + 5);
    drain();
    set_reg(kts_pkg::CFG_LOOP_DURATION, 32'h8000_0000);
    sample_at(32'h7fff_ffff);
    drain();

    // Loop duration at the last key time, then at the largest positive time.
    set_reg(kts_pkg::CFG_LOOP_DURATION, slot_time[kts_pkg::MAX_KEYS-1]);
    sample_at(32'h7fff_ffff);
    sample_at(slot_time[kts_pkg::MAX_KEYS-1] * 2);
    sample_at(slot_time[kts_pkg::MAX_KEYS-1] + 1);
    drain();
    set_reg(kts_pkg::CFG_LOOP_DURATION, 32'h7fff_ffff);
    sample_at(32'h7fff_ffff);
    drain();
    set_reg(kts_pkg::CFG_KEY_COUNT, 32'd1);
    sample_at(slot_time[0]);
    sample_at(32'h0000_0001);
    drain();

    // Random phases under each idle mode.
    for (int ph = 0; ph < 12; ph++) begin
      idle_mode = ph % 4;
      drain();
      set_reg(kts_pkg::CFG_KEY_COUNT, count_opts[$urandom_range(5)] == 33 ?
              $urandom_range(2, 64) : count_opts[$urandom_range(5)]);
      set_reg(kts_pkg::CFG_LOOPING, $urandom_range(3) != 0);
      case ($urandom_range(4))
        0:       d = slot_time[kts_pkg::MAX_KEYS-1];
        1:       d = slot_time[kts_pkg::MAX_KEYS-1] + $urandom_range(32'h00ff_ffff);
        2:       d = 32'd0;
        3:       d = 32'h8000_0000 | $urandom;
        default: d = $urandom_range(32'h7fff_ffff);
      endcase
      set_reg(kts_pkg::CFG_LOOP_DURATION, d);
      set_reg(kts_pkg::CFG_EMPTY_FILL, $urandom);
      for (int n = 0; n < 80; n++) begin
        if (ph == 2 && n == 10) want_hold = 1'b1;
        if (ph == 5 && n == 40) begin
          in_chan.valid <= 1'b0;
          @(negedge clk);
          while (pending != 0) @(negedge clk);
        end
        if ($urandom_range(4) == 0)
          random_write();
        else
          sample_at(pick_time());
      end
    end

    // Wait for every result, then a settle time.
    drain();
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
